// File: sv/omv_pkg.sv
// ----------------------------------------------------------------------------
// omv_pkg
// Shared widths, constants and controller/datapath types for the online
// mean and variance unit.
// ----------------------------------------------------------------------------
package omv_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;
    localparam int VAR_W    = 63;
    localparam int ACC_W    = 96;
    localparam int STEP_W   = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};

    // Index of the last quotient bit for each division; the serial divider counts down from it to zero.
    localparam logic [STEP_W-1:0] MEAN_DIV_LAST = STEP_W'(SAMPLE_W);
    localparam logic [STEP_W-1:0] VAR_DIV_LAST  = STEP_W'(VAR_W - 1);

    typedef enum logic [1:0] {
        MUL_VAR_LO,
        MUL_VAR_HI,
        MUL_DELTA
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_CORR,
        ACC_ADD_PROD,
        ACC_ADD_PROD_HI
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     delta;
        logic     div_step;
        logic     mean_upd;
        logic     d2;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     var_init;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        logic first;
    } t_sts;

endpackage

// File: sv/omv_in_if.sv
// ----------------------------------------------------------------------------
// omv_in_if
// Input channel carrying one calibrated sample word.
// ----------------------------------------------------------------------------
interface omv_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [omv_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: sv/omv_out_if.sv
// ----------------------------------------------------------------------------
// omv_out_if
// Result channel carrying count, mean and variance.
// ----------------------------------------------------------------------------
interface omv_out_if;
    logic                                valid;
    logic                                ready;
    logic        [omv_pkg::COUNT_W-1:0]  count;
    logic signed [omv_pkg::SAMPLE_W-1:0] mean;
    logic        [omv_pkg::VAR_W-1:0]    variance;

    modport source (output valid, output count, output mean, output variance, input ready);
    modport sink   (input valid, input count, input mean, input variance, output ready);
endinterface

// File: sv/omv_dp.sv
// ----------------------------------------------------------------------------
// omv_dp
// Datapath: running state, one 32x32 multiplier, a 96-bit accumulator and
// a restoring bit-serial divider shared by the mean and variance updates.
// ----------------------------------------------------------------------------
module omv_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  omv_pkg::t_cmd                       i_cmd,
    output omv_pkg::t_sts                       o_sts,
    input  logic signed [omv_pkg::SAMPLE_W-1:0] i_sample,
    output logic        [omv_pkg::COUNT_W-1:0]  o_count,
    output logic signed [omv_pkg::SAMPLE_W-1:0] o_mean,
    output logic        [omv_pkg::VAR_W-1:0]    o_variance
);

    // Running state.
    logic [omv_pkg::COUNT_W-1:0]  r_total;
    logic [omv_pkg::SAMPLE_W-1:0] r_mean;
    logic [omv_pkg::VAR_W-1:0]    r_var;

    // Per-word working registers.
    logic [omv_pkg::SAMPLE_W-1:0] r_x;
    logic [omv_pkg::COUNT_W-1:0]  r_n;
    logic                         r_dneg;
    logic [omv_pkg::SAMPLE_W:0]   r_dmag;
    logic [omv_pkg::SAMPLE_W-1:0] r_mnew;
    logic [omv_pkg::SAMPLE_W:0]   r_d2mag;
    logic [63:0]                  r_prod;
    logic [omv_pkg::ACC_W-1:0]    r_acc;
    logic                         r_sat;

    // Divider.
    logic [omv_pkg::COUNT_W-1:0]  r_rem;
    logic [omv_pkg::VAR_W-1:0]    r_dvd;
    logic [omv_pkg::VAR_W-1:0]    r_quo;
    logic [omv_pkg::COUNT_W-1:0]  r_dvs;

    logic [omv_pkg::COUNT_W-1:0]  w_n_inc;
    logic [omv_pkg::COUNT_W-1:0]  w_nm1;
    logic [omv_pkg::COUNT_W-1:0]  w_nm2;
    logic [omv_pkg::SAMPLE_W:0]   w_delta;
    logic [omv_pkg::SAMPLE_W:0]   w_dmag;
    logic [omv_pkg::SAMPLE_W+1:0] w_qs;
    logic [omv_pkg::SAMPLE_W+1:0] w_mnew;
    logic [omv_pkg::SAMPLE_W:0]   w_d2;
    logic [31:0]                  w_ma;
    logic [31:0]                  w_mb;
    logic [omv_pkg::ACC_W-1:0]    w_corr;
    logic [omv_pkg::COUNT_W:0]    w_trial;
    logic [omv_pkg::COUNT_W:0]    w_sub;
    logic                         w_ge;
    logic [omv_pkg::VAR_W-1:0]    w_var_new;

    assign w_n_inc = (r_total == omv_pkg::COUNT_MAX) ? r_total : r_total + 1'b1;
    assign w_nm1   = r_n - 1'b1;
    assign w_nm2   = r_n - 2'd2;

    assign w_delta = {r_x[31], r_x} - {r_mean[31], r_mean};
    assign w_dmag  = w_delta[32] ? (~w_delta + 1'b1) : w_delta;

    // Mean step: truncate toward zero by dividing the magnitude, then re-apply the sign.
    assign w_qs   = r_dneg ? (~{1'b0, r_quo[32:0]} + 1'b1) : {1'b0, r_quo[32:0]};
    assign w_mnew = {{2{r_mean[31]}}, r_mean} + w_qs;

    assign w_d2 = {r_x[31], r_x} - {r_mnew[31], r_mnew};

    always_comb begin
        unique case (i_cmd.mul_sel)
            omv_pkg::MUL_VAR_LO: begin
                w_ma = r_var[31:0];
                w_mb = w_nm2;
            end
            omv_pkg::MUL_VAR_HI: begin
                w_ma = {1'b0, r_var[62:32]};
                w_mb = w_nm2;
            end
            omv_pkg::MUL_DELTA: begin
                w_ma = r_dmag[31:0];
                w_mb = r_d2mag[31:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Contribution of bit 32 of either magnitude to the product of the two.
    assign w_corr = (r_dmag[32] ? {31'b0, r_d2mag, 32'b0} : '0)
                  + (r_d2mag[32] ? {32'b0, r_dmag[31:0], 32'b0} : '0);

    assign w_trial = {r_rem, r_dvd[omv_pkg::VAR_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    assign w_var_new = o_sts.first ? '0 : (r_sat ? omv_pkg::VAR_MAX : r_quo);

    assign o_sts.first = (r_n == omv_pkg::COUNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_mean  <= '0;
            r_var   <= '0;
        end else if (i_cmd.commit) begin
            r_total <= r_n;
            r_mean  <= r_mnew;
            r_var   <= w_var_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
            r_n <= w_n_inc;
        end
        if (i_cmd.delta) begin
            r_dneg <= w_delta[32];
            r_dmag <= w_dmag;
            r_rem  <= '0;
            r_dvd  <= {w_dmag, 30'b0};
            r_dvs  <= r_n;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[31:0] : w_trial[31:0];
            r_dvd <= {r_dvd[omv_pkg::VAR_W-2:0], 1'b0};
            r_quo <= {r_quo[omv_pkg::VAR_W-2:0], w_ge};
        end
        if (i_cmd.mean_upd) begin
            r_mnew <= w_mnew[31:0];
        end
        if (i_cmd.d2) begin
            r_d2mag <= w_d2[32] ? (~w_d2 + 1'b1) : w_d2;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        unique case (i_cmd.acc_op)
            omv_pkg::ACC_HOLD:        r_acc <= r_acc;
            omv_pkg::ACC_LOAD_CORR:   r_acc <= w_corr;
            omv_pkg::ACC_ADD_PROD:    r_acc <= r_acc + {32'b0, r_prod};
            omv_pkg::ACC_ADD_PROD_HI: r_acc <= r_acc + {r_prod, 32'b0};
            default:                  r_acc <= r_acc;
        endcase
        // The top 33 bits of the numerator decide saturation; below that the
        // remainder starts from them and 63 quotient bits remain.
        if (i_cmd.var_init) begin
            r_sat <= r_acc[95:63] >= {1'b0, w_nm1};
            r_rem <= r_acc[94:63];
            r_dvd <= r_acc[62:0];
            r_dvs <= w_nm1;
        end
    end

    assign o_count    = r_total;
    assign o_mean     = r_mean;
    assign o_variance = r_var;

endmodule

// File: sv/omv_ctrl.sv
// ----------------------------------------------------------------------------
// omv_ctrl
// Controller: sequences the datapath through the mean division, the
// numerator products and the variance division, and owns the handshakes.
// ----------------------------------------------------------------------------
module omv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  omv_pkg::t_sts i_sts,
    output omv_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_MDIV,
        S_MEAN,
        S_D2,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_VINIT,
        S_VDIV,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [omv_pkg::STEP_W-1:0]  r_cnt;
    logic                        r_out_valid;
    logic                        w_can_commit;

    assign w_can_commit = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = omv_pkg::MUL_VAR_LO;
        o_cmd.acc_op   = omv_pkg::ACC_HOLD;
        unique case (r_state)
            S_IDLE:  o_cmd.load     = i_in_valid;
            S_DELTA: o_cmd.delta    = 1'b1;
            S_MDIV:  o_cmd.div_step = 1'b1;
            S_MEAN:  o_cmd.mean_upd = 1'b1;
            S_D2:    o_cmd.d2       = 1'b1;
            S_MUL_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = omv_pkg::MUL_VAR_LO;
                o_cmd.acc_op  = omv_pkg::ACC_LOAD_CORR;
            end
            S_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = omv_pkg::MUL_VAR_HI;
                o_cmd.acc_op  = omv_pkg::ACC_ADD_PROD;
            end
            S_MUL_C: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = omv_pkg::MUL_DELTA;
                o_cmd.acc_op  = omv_pkg::ACC_ADD_PROD_HI;
            end
            S_MUL_D: o_cmd.acc_op   = omv_pkg::ACC_ADD_PROD;
            S_VINIT: o_cmd.var_init = 1'b1;
            S_VDIV:  o_cmd.div_step = 1'b1;
            S_DONE:  o_cmd.commit   = w_can_commit;
            default: o_cmd.load     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces one that is taken in the same cycle.
            if (r_state == S_DONE && w_can_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_cnt   <= omv_pkg::MEAN_DIV_LAST;
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MEAN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MEAN:  r_state <= S_D2;
                S_D2:    r_state <= i_sts.first ? S_DONE : S_MUL_A;
                S_MUL_A: r_state <= S_MUL_B;
                S_MUL_B: r_state <= S_MUL_C;
                S_MUL_C: r_state <= S_MUL_D;
                S_MUL_D: r_state <= S_VINIT;
                S_VINIT: begin
                    r_cnt   <= omv_pkg::VAR_DIV_LAST;
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_can_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/online_mean_variance_unit.sv
// ----------------------------------------------------------------------------
// online_mean_variance_unit
// Welford running mean and sample variance over signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Each accepted sample word returns one result word with the saturating
// count, the Q16.16 mean and the Q32.32 variance. One word is in work at a
// time: the next word is accepted only after its result is committed. The
// time per word is set by the single bit-serial divider, which produces 33
// quotient bits for the mean and 63 for the variance, and by the steps on
// the shared 32x32 multiplier; the first sample skips both of the variance
// steps. A finished result is held in the output register while the next
// sample is accepted and processed; the update waits only if that result
// is still untaken when the next one is due.
module online_mean_variance_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    omv_in_if.sink     i_in,
    omv_out_if.source  o_out
);

    omv_pkg::t_cmd w_cmd;
    omv_pkg::t_sts w_sts;

    omv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    omv_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_sample   (i_in.sample),
        .o_count    (o_out.count),
        .o_mean     (o_out.mean),
        .o_variance (o_out.variance)
    );

    // A word is worked on alone: acceptance always drops ready.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while a word was in work");

    // The count shown with a result is never zero.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.count != '0)
        else $error("result carries a zero count");

    // A single sample has no spread.
    a_first_var_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.count == omv_pkg::COUNT_W'(1) |-> o_out.variance == '0)
        else $error("non-zero variance after the first sample");

    // The state changes only when a new result is raised.
    a_result_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out.valid)
        else $error("state updated without a result");

endmodule

// File: sim/tb_online_mean_variance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_online_mean_variance_unit
// Self-checking bench for the Welford running mean and variance unit.
// ----------------------------------------------------------------------------
// Sample words are pushed through the input channel in bursts with random
// gaps, while the result channel stalls in changing patterns. A directed table
// of extremes and sign changes comes first. Random words follow, clustered
// around a drifting centre, over the full range, at the extremes or near
// zero. Every accepted word is folded into a bench-side Welford predictor,
// and each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_online_mean_variance_unit;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    localparam int N_RANDOM      = 932;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int N_DIRECTED    = 18;

    typedef struct packed {
        logic [omv_pkg::COUNT_W-1:0]         count;
        logic signed [omv_pkg::SAMPLE_W-1:0] mean;
        logic [omv_pkg::VAR_W-1:0]           variance;
    } t_stats;

    // A row either carries its result written out, or leaves it to the predictor.
    typedef struct packed {
        logic signed [omv_pkg::SAMPLE_W-1:0] sample;
        logic                                fixed_want;
        t_stats                              want;
    } t_probe;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_SLUGGISH
    } t_sink_mode;

    localparam logic signed [omv_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic signed [omv_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

    localparam t_probe DIRECTED_ROWS [N_DIRECTED] = '{
        '{32'sh0000_0000, 1'b1, '{32'd1, 32'sd0, 63'd0}},
        '{32'sh0000_0000, 1'b1, '{32'd2, 32'sd0, 63'd0}},
        '{32'sh0000_0000, 1'b1, '{32'd3, 32'sd0, 63'd0}},
        '{32'sh7FFF_FFFF, 1'b0, '0},
        '{32'sh8000_0000, 1'b0, '0},
        '{32'sh7FFF_FFFF, 1'b0, '0},
        '{32'sh8000_0000, 1'b0, '0},
        '{32'sh0001_0000, 1'b0, '0},
        '{32'shFFFF_0000, 1'b0, '0},
        '{32'sh0000_0001, 1'b0, '0},
        '{32'shFFFF_FFFF, 1'b0, '0},
        '{32'sh8000_0001, 1'b0, '0},
        '{32'sh7FFF_FFFE, 1'b0, '0},
        '{32'sh5555_5555, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b0, '0},
        '{32'sh1234_5678, 1'b0, '0},
        '{32'sh1234_5678, 1'b0, '0},
        '{32'sh1234_5678, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    omv_in_if  in_ch ();
    omv_out_if out_ch ();

    online_mean_variance_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state, cleared as the block is after reset.
    logic [omv_pkg::COUNT_W-1:0]         tally     = '0;
    logic signed [omv_pkg::SAMPLE_W-1:0] avg       = '0;
    logic [omv_pkg::VAR_W-1:0]           spread_sq = '0;

    t_stats pending_stats [$];
    int     mismatches    = 0;
    int     words_sent    = 0;
    int     results_seen  = 0;
    int     cycle_count   = 0;

    t_sink_mode sink_mode  = SINK_OPEN;
    int         mode_timer = 0;
    int         stall_left = 0;

    function automatic t_stats fold_sample(input logic signed [omv_pkg::SAMPLE_W-1:0] x);
        longint       n;
        longint       xl;
        longint       m_old;
        longint       m_new;
        longint       delta;
        longint       delta2;
        logic [127:0] numer;
        logic [127:0] quot;
        t_stats       r;
        if (tally != omv_pkg::COUNT_MAX)
            tally = tally + 1'b1;
        n      = {32'b0, tally};
        xl     = x;
        m_old  = avg;
        delta  = xl - m_old;
        m_new  = m_old + delta / n;
        delta2 = xl - m_new;
        avg    = m_new[omv_pkg::SAMPLE_W-1:0];
        if (n <= 1) begin
            spread_sq = '0;
        end else begin
            // Both deltas share a sign, so the product of magnitudes is exact.
            numer = 128'(spread_sq) * 128'(n - 2)
                  + 128'(delta < 0 ? -delta : delta) * 128'(delta2 < 0 ? -delta2 : delta2);
            quot  = numer / 128'(n - 1);
            spread_sq = (quot > 128'(omv_pkg::VAR_MAX)) ? omv_pkg::VAR_MAX
                                                       : quot[omv_pkg::VAR_W-1:0];
        end
        r.count    = tally;
        r.mean     = avg;
        r.variance = spread_sq;
        return r;
    endfunction

    // Holds the word on the channel until it is taken; valid is left high.
    task automatic send_sample(input logic signed [omv_pkg::SAMPLE_W-1:0] x,
                               input logic use_fixed, input t_stats fixed);
        t_stats predicted;
        in_ch.valid  <= 1'b1;
        in_ch.sample <= x;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        predicted = fold_sample(x);
        pending_stats.push_back(use_fixed ? fixed : predicted);
        words_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_stats want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_stats.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, expected none, actual count %0d",
                         $time, out_ch.count);
            end else begin
                want = pending_stats.pop_front();
                report_field("count", {32'b0, want.count}, {32'b0, out_ch.count});
                report_field("mean", {32'b0, want.mean}, {32'b0, out_ch.mean});
                report_field("variance", {1'b0, want.variance}, {1'b0, out_ch.variance});
            end
        end
    end

    // The receiver switches between open, choppy and long-stall behaviour.
    always @(posedge i_clk) begin
        logic take;
        take = 1'b1;
        if (mode_timer == 0) begin
            sink_mode  <= t_sink_mode'($urandom_range(0, 2));
            mode_timer <= $urandom_range(1500, 4000);
        end else begin
            mode_timer <= mode_timer - 1;
        end
        if (stall_left != 0) begin
            take = 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (sink_mode)
                SINK_OPEN: begin
                    take = 1'b1;
                end
                SINK_CHOPPY: begin
                    take = ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if ($urandom_range(0, 40) == 0) begin
                        take = 1'b0;
                        stall_left <= $urandom_range(20, 120);
                    end
                end
            endcase
        end
        out_ch.ready <= take;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_stats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic signed [omv_pkg::SAMPLE_W-1:0] x;
        logic signed [omv_pkg::SAMPLE_W-1:0] centre;
        logic [omv_pkg::SAMPLE_W-1:0]        offset;
        int                                  pick;
        int                                  burst_left;
        logic                                gaps_on;

        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].fixed_want,
                        DIRECTED_ROWS[i].want);
        drain_results();

        centre     = $urandom;
        burst_left = $urandom_range(1, 8);
        for (int k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // Cluster round the centre so that the variance settles and then drifts.
                offset = $urandom & ((32'h1 << $urandom_range(0, 24)) - 1);
                x = $urandom_range(0, 1) ? centre + offset : centre - offset;
            end else if (pick < 75) begin
                x = $urandom;
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0:       x = SAMPLE_MIN;
                    1:       x = SAMPLE_MAX;
                    2:       x = '0;
                    default: x = '1;
                endcase
            end else begin
                x = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            end
            if ($urandom_range(0, 59) == 0)
                centre = $urandom;

            send_sample(x, 1'b0, '0);

            gaps_on = ((k / 120) % 3) != 1;
            if (k % 250 == 249) begin
                drain_results();
            end else if (gaps_on) begin
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(1, 150)
                                                             : $urandom_range(0, 12));
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample words (%0d from the directed table), checked %0d results.",
                 words_sent, N_DIRECTED, results_seen);
        $display("Samples covered both signed extremes, clustered runs and full-range noise.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: online_mean_variance_unit.f
sv/omv_pkg.sv
sv/omv_in_if.sv
sv/omv_out_if.sv
sv/omv_dp.sv
sv/omv_ctrl.sv
sv/online_mean_variance_unit.sv
sim/tb_online_mean_variance_unit.sv
